// File: rtl/c2d_pkg.sv
// Package for the direct 2D convolution engine.
// Holds command and register codes, item structs, the sequencer state type
// and the default store sizes. No dependencies.
package c2d_pkg;

    localparam int DEF_MAX_IN_CHANNELS = 16;
    localparam int DEF_MAX_HEIGHT      = 32;
    localparam int DEF_MAX_WIDTH       = 32;
    localparam int DEF_MAX_FILTERS     = 16;
    localparam int DEF_MAX_KERNEL      = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTERS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING     = 3'd5;

    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_PIXEL  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [13:0]        index;
        logic signed [15:0] value;
        logic [3:0]         out_filter;
        logic [4:0]         out_row;
        logic [4:0]         out_col;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               saturated;
        logic               bad_request;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        logic done;
        logic saturated;
    } t_mac_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_LOAD,
        S_CHECK,
        S_START,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// File: rtl/c2d_stream_if.sv
// Valid/ready stream channel carrying one item of type T.
// Used by the convolution engine top level; no other dependencies.
interface c2d_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/c2d_mac.sv
// Shared multiply-accumulate unit with 32-bit saturation of the sum.
// Depends on c2d_pkg for the control and status structs.
module c2d_mac #(
    parameter int ACC_W = 45
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c2d_pkg::t_mac_ctl   i_ctl,
    input  logic signed [15:0]  i_pixel,
    input  logic signed [15:0]  i_weight,
    output logic signed [31:0]  o_sum,
    output c2d_pkg::t_mac_sts   o_sts
);

    localparam logic signed [ACC_W-1:0] AccMax = ACC_W'($signed(32'h7fff_ffff));
    localparam logic signed [ACC_W-1:0] AccMin = ACC_W'($signed(32'h8000_0000));

    logic                    r_v2;
    logic                    r_l2;
    logic                    r_done;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    over_hi;
    logic                    over_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2   <= 1'b0;
            r_l2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v2 <= i_ctl.valid;
            r_l2 <= i_ctl.last;
            if (i_ctl.clear) begin
                r_done <= 1'b0;
            end else if (r_l2) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_pixel * i_weight;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign over_hi = (r_acc > AccMax);
    assign over_lo = (r_acc < AccMin);

    always_comb begin
        if (over_hi) begin
            o_sum = 32'sh7fff_ffff;
        end else if (over_lo) begin
            o_sum = $signed(32'h8000_0000);
        end else begin
            o_sum = r_acc[31:0];
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.saturated = over_hi || over_lo;

endmodule

// File: rtl/conv2d_direct_engine.sv
// Top level of the direct 2D convolution engine: config registers, pixel
// and weight stores, tap sequencer and result register.
// Depends on c2d_pkg, c2d_stream_if and c2d_mac.
//
// Items arrive on i_item and are taken one at a time. A weight or pixel load
// passes through the wait and load states until the engine is ready again and
// gives no result. A compute walks every tap of every in-channel in order, one
// tap per cycle through the single multiply-accumulate unit, padding taps
// included (they add nothing), so it occupies the engine for address setup in
// the wait, check and start states, the tap walk, pipeline drain through the
// registered store reads and the multiplier, and the hand-over of the result
// to the output register. A request with a filter, row or column outside the
// configured size goes from the check to the finish state and returns an
// error item. The result register lets a new item start while an earlier
// result waits; a compute that finishes before that result is taken holds
// until it is. Stores are not cleared at reset.
module conv2d_direct_engine #(
    parameter int MAX_IN_CHANNELS = c2d_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_HEIGHT      = c2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH       = c2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FILTERS     = c2d_pkg::DEF_MAX_FILTERS,
    parameter int MAX_KERNEL      = c2d_pkg::DEF_MAX_KERNEL
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    c2d_stream_if.sink                      i_item,
    c2d_stream_if.source                    o_result
);

    localparam int PIX_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int ACC_W     = 33 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);

    c2d_pkg::t_state r_state;
    c2d_pkg::t_state n_state;

    logic [4:0] r_cfg_ic;
    logic [5:0] r_cfg_h;
    logic [5:0] r_cfg_w;
    logic [4:0] r_cfg_f;
    logic [2:0] r_cfg_k;
    logic [1:0] r_cfg_pad;

    logic [4:0] ic_e;
    logic [5:0] h_e;
    logic [5:0] w_e;
    logic [4:0] f_e;
    logic [2:0] k_e;
    logic [1:0] pad_e;

    logic [9:0]  r_fi;
    logic [5:0]  r_kk;
    logic [11:0] r_hw;
    logic [15:0] r_wlim;
    logic [10:0] r_ickk;
    logic [16:0] r_plim;

    c2d_pkg::t_in_item  r_item;
    c2d_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               r_bad;

    logic signed [8:0]  r_sy0;
    logic signed [8:0]  r_sx0;
    logic signed [8:0]  r_sy;
    logic signed [8:0]  r_sx;
    logic signed [8:0]  sy0;
    logic signed [8:0]  sx0;
    logic signed [15:0] r_rowmul;
    logic [WGT_AW-1:0]  r_wbase;
    logic [PIX_AW-1:0]  r_chptr;
    logic [PIX_AW-1:0]  r_rowptr;
    logic [PIX_AW-1:0]  r_pa;
    logic [WGT_AW-1:0]  r_wa;
    logic [PIX_AW-1:0]  ptr0;
    logic [4:0]         r_c;
    logic [2:0]         r_ky;
    logic [2:0]         r_kx;
    logic               r_v1;
    logic               r_l1;

    logic signed [15:0] r_pix_mem [PIX_DEPTH];
    logic signed [15:0] r_wgt_mem [WGT_DEPTH];
    logic signed [15:0] r_pix_rd;
    logic signed [15:0] r_wgt_rd;

    logic bad_now;
    logic tap_ok;
    logic last_kx;
    logic last_ky;
    logic last_c;
    logic last_tap;
    logic out_free;

    logic item_ready;
    logic wgt_we;
    logic pix_we;
    logic issue;
    logic out_load;

    c2d_pkg::t_mac_ctl  mac_ctl;
    c2d_pkg::t_mac_sts  mac_sts;
    logic signed [31:0] mac_sum;

    // Configuration registers and their values clamped into range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ic  <= 5'd1;
            r_cfg_h   <= 6'd32;
            r_cfg_w   <= 6'd32;
            r_cfg_f   <= 5'd1;
            r_cfg_k   <= 3'd3;
            r_cfg_pad <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                c2d_pkg::REG_IN_CHANNELS: r_cfg_ic  <= i_cfg_data[4:0];
                c2d_pkg::REG_HEIGHT:      r_cfg_h   <= i_cfg_data[5:0];
                c2d_pkg::REG_WIDTH:       r_cfg_w   <= i_cfg_data[5:0];
                c2d_pkg::REG_FILTERS:     r_cfg_f   <= i_cfg_data[4:0];
                c2d_pkg::REG_KERNEL_SIZE: r_cfg_k   <= i_cfg_data[2:0];
                c2d_pkg::REG_PADDING:     r_cfg_pad <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ic_e  = (r_cfg_ic == '0) ? 5'd1 :
                (32'(r_cfg_ic) > MAX_IN_CHANNELS) ? 5'(MAX_IN_CHANNELS) : r_cfg_ic;
        h_e   = (r_cfg_h == '0) ? 6'd1 :
                (32'(r_cfg_h) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : r_cfg_h;
        w_e   = (r_cfg_w == '0) ? 6'd1 :
                (32'(r_cfg_w) > MAX_WIDTH) ? 6'(MAX_WIDTH) : r_cfg_w;
        f_e   = (r_cfg_f == '0) ? 5'd1 :
                (32'(r_cfg_f) > MAX_FILTERS) ? 5'(MAX_FILTERS) : r_cfg_f;
        k_e   = (r_cfg_k == '0) ? 3'd1 :
                (32'(r_cfg_k) > MAX_KERNEL) ? 3'(MAX_KERNEL) : r_cfg_k;
        pad_e = (r_cfg_pad == 2'd3) ? 2'd2 : r_cfg_pad;
    end

    // Size products, registered; r_wlim, r_ickk and r_plim build on the registered r_fi, r_kk and r_hw.
    always_ff @(posedge i_clk) begin
        r_fi   <= 10'(f_e) * 10'(ic_e);
        r_kk   <= 6'(k_e) * 6'(k_e);
        r_hw   <= 12'(h_e) * 12'(w_e);
        r_wlim <= 16'(r_fi) * 16'(r_kk);
        r_ickk <= 11'(ic_e) * 11'(r_kk);
        r_plim <= 17'(ic_e) * 17'(r_hw);
    end

    // Tap walk status.
    assign sy0 = $signed({4'b0000, r_item.out_row}) - $signed({7'b0000000, pad_e});
    assign sx0 = $signed({4'b0000, r_item.out_col}) - $signed({7'b0000000, pad_e});
    assign ptr0 = PIX_AW'(32'(r_rowmul) + 32'(r_sx0));

    assign bad_now = (r_item.out_filter >= 4'(f_e) && f_e < 5'd16) ||
                     ({1'b0, r_item.out_row} >= h_e) ||
                     ({1'b0, r_item.out_col} >= w_e);

    assign tap_ok = !r_sy[8] && (r_sy < $signed({3'b000, h_e})) &&
                    !r_sx[8] && (r_sx < $signed({3'b000, w_e}));

    assign last_kx  = (r_kx == k_e - 3'd1);
    assign last_ky  = (r_ky == k_e - 3'd1);
    assign last_c   = (r_c == ic_e - 5'd1);
    assign last_tap = last_kx && last_ky && last_c;
    assign out_free = !r_out_valid || o_result.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            c2d_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_state = c2d_pkg::S_WAIT;
                end
            end
            c2d_pkg::S_WAIT: begin
                case (r_item.command)
                    c2d_pkg::CMD_LOAD_WEIGHT: n_state = c2d_pkg::S_LOAD;
                    c2d_pkg::CMD_LOAD_PIXEL:  n_state = c2d_pkg::S_LOAD;
                    c2d_pkg::CMD_COMPUTE:     n_state = c2d_pkg::S_CHECK;
                    default:                  n_state = c2d_pkg::S_IDLE;
                endcase
            end
            c2d_pkg::S_LOAD:  n_state = c2d_pkg::S_IDLE;
            c2d_pkg::S_CHECK: n_state = bad_now ? c2d_pkg::S_FINISH : c2d_pkg::S_START;
            c2d_pkg::S_START: n_state = c2d_pkg::S_RUN;
            c2d_pkg::S_RUN: begin
                if (last_tap) begin
                    n_state = c2d_pkg::S_DRAIN;
                end
            end
            c2d_pkg::S_DRAIN: begin
                if (mac_sts.done) begin
                    n_state = c2d_pkg::S_FINISH;
                end
            end
            c2d_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = c2d_pkg::S_IDLE;
                end
            end
            default: n_state = c2d_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        item_ready = 1'b0;
        wgt_we     = 1'b0;
        pix_we     = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            c2d_pkg::S_IDLE: item_ready = 1'b1;
            c2d_pkg::S_LOAD: begin
                wgt_we = (r_item.command == c2d_pkg::CMD_LOAD_WEIGHT) &&
                         (32'(r_item.index) < 32'(r_wlim));
                pix_we = (r_item.command == c2d_pkg::CMD_LOAD_PIXEL) &&
                         (32'(r_item.index) < 32'(r_plim));
            end
            c2d_pkg::S_RUN:    issue = 1'b1;
            c2d_pkg::S_FINISH: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c2d_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_l1        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue && tap_ok;
            r_l1    <= issue && last_tap;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture, address setup, tap counters and result capture.
    always_ff @(posedge i_clk) begin
        if (item_ready && i_item.valid) begin
            r_item <= i_item.data;
        end
        case (r_state)
            c2d_pkg::S_CHECK: begin
                r_bad    <= bad_now;
                r_wbase  <= WGT_AW'(15'(r_item.out_filter) * 15'(r_ickk));
                r_rowmul <= $signed({{7{sy0[8]}}, sy0}) * $signed({10'b0, w_e});
                r_sy0    <= sy0;
                r_sx0    <= sx0;
                r_sy     <= sy0;
                r_sx     <= sx0;
                r_c      <= '0;
                r_ky     <= '0;
                r_kx     <= '0;
            end
            c2d_pkg::S_START: begin
                r_chptr  <= ptr0;
                r_rowptr <= ptr0;
                r_pa     <= ptr0;
                r_wa     <= r_wbase;
            end
            c2d_pkg::S_RUN: begin
                r_wa <= r_wa + WGT_AW'(1);
                if (!last_kx) begin
                    r_kx <= r_kx + 3'd1;
                    r_sx <= r_sx + 9'sd1;
                    r_pa <= r_pa + PIX_AW'(1);
                end else if (!last_ky) begin
                    r_kx     <= '0;
                    r_ky     <= r_ky + 3'd1;
                    r_sx     <= r_sx0;
                    r_sy     <= r_sy + 9'sd1;
                    r_rowptr <= r_rowptr + PIX_AW'(w_e);
                    r_pa     <= r_rowptr + PIX_AW'(w_e);
                end else if (!last_c) begin
                    r_kx     <= '0;
                    r_ky     <= '0;
                    r_c      <= r_c + 5'd1;
                    r_sx     <= r_sx0;
                    r_sy     <= r_sy0;
                    r_chptr  <= r_chptr + PIX_AW'(r_hw);
                    r_rowptr <= r_chptr + PIX_AW'(r_hw);
                    r_pa     <= r_chptr + PIX_AW'(r_hw);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.result_value <= r_bad ? 32'sd0 : mac_sum;
            r_out.saturated    <= !r_bad && mac_sts.saturated;
            r_out.bad_request  <= r_bad;
        end
    end

    // Stores.
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[PIX_AW'(r_item.index)] <= r_item.value;
        end
        r_pix_rd <= r_pix_mem[r_pa];
    end

    always_ff @(posedge i_clk) begin
        if (wgt_we) begin
            r_wgt_mem[WGT_AW'(r_item.index)] <= r_item.value;
        end
        r_wgt_rd <= r_wgt_mem[r_wa];
    end

    assign mac_ctl.clear = (r_state == c2d_pkg::S_START);
    assign mac_ctl.valid = r_v1;
    assign mac_ctl.last  = r_l1;

    c2d_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_pixel  (r_pix_rd),
        .i_weight (r_wgt_rd),
        .o_sum    (mac_sum),
        .o_sts    (mac_sts)
    );

    assign i_item.ready   = item_ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state == c2d_pkg::S_WAIT))
        else $error("accepted item did not enter the sequencer");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bad_request) |->
        (r_out.result_value == 32'sd0 && !r_out.saturated))
        else $error("error result carries a value");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2d_pkg::S_RUN) |-> (r_kx < k_e && r_ky < k_e && r_c < ic_e))
        else $error("tap counter outside kernel");

    a_no_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2d_pkg::S_RUN) |-> !mac_sts.done)
        else $error("accumulator finished before the last tap");

    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wgt_we || pix_we) |-> (r_state == c2d_pkg::S_LOAD && !(wgt_we && pix_we)))
        else $error("store write outside a load");
`endif

endmodule

// File: sim/conv2d_direct_engine_check.sv
`timescale 1ns / 1ps
// Checker for the direct 2D convolution engine: watches the config port and both
// item channels, predicts every compute result and compares it field by field.
// Depends on c2d_pkg.
module conv2d_direct_engine_check
    import c2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_item_valid,
    input  logic                  i_item_ready,
    input  t_in_item              i_item_data,
    input  logic                  i_result_valid,
    input  logic                  i_result_ready,
    input  t_out_item             i_result_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PIX_CELLS = DEF_MAX_IN_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
    localparam int WGT_CELLS = DEF_MAX_FILTERS * DEF_MAX_IN_CHANNELS
                             * DEF_MAX_KERNEL * DEF_MAX_KERNEL;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic signed [15:0] pixel_mem  [PIX_CELLS];
    logic signed [15:0] weight_mem [WGT_CELLS];

    logic [4:0] ic_reg;
    logic [5:0] h_reg;
    logic [5:0] w_reg;
    logic [4:0] f_reg;
    logic [2:0] k_reg;
    logic [1:0] pad_reg;

    int unsigned nc, nh, nw, nf, nk;
    int          npad;

    t_out_item conv_results_due [$];
    int        mismatch_count = 0;

    function automatic int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic settle_sizes();
        nc   = fit(ic_reg, 1, DEF_MAX_IN_CHANNELS);
        nh   = fit(h_reg, 1, DEF_MAX_HEIGHT);
        nw   = fit(w_reg, 1, DEF_MAX_WIDTH);
        nf   = fit(f_reg, 1, DEF_MAX_FILTERS);
        nk   = fit(k_reg, 1, DEF_MAX_KERNEL);
        npad = int'(fit(pad_reg, 0, 2));
    endtask

    function automatic t_out_item conv_point(t_in_item it);
        int unsigned pa, wa;
        int          sy, sx;
        longint      acc;
        t_out_item   r;
        r = '0;
        if (it.out_filter >= nf || it.out_row >= nh || it.out_col >= nw) begin
            r.bad_request = 1'b1;
            return r;
        end
        acc = 0;
        for (int unsigned c = 0; c < nc; c++) begin
            for (int unsigned ky = 0; ky < nk; ky++) begin
                sy = int'(it.out_row) + int'(ky) - npad;
                if (sy < 0 || sy >= int'(nh)) continue;
                for (int unsigned kx = 0; kx < nk; kx++) begin
                    sx = int'(it.out_col) + int'(kx) - npad;
                    if (sx < 0 || sx >= int'(nw)) continue;
                    pa = (c * nh + unsigned'(sy)) * nw + unsigned'(sx);
                    wa = ((it.out_filter * nc + c) * nk + ky) * nk + kx;
                    if (pa < PIX_CELLS && wa < WGT_CELLS)
                        acc += longint'(pixel_mem[pa]) * longint'(weight_mem[wa]);
                end
            end
        end
        if (acc > SUM_MAX) begin
            acc = SUM_MAX;
            r.saturated = 1'b1;
        end
        if (acc < SUM_MIN) begin
            acc = SUM_MIN;
            r.saturated = 1'b1;
        end
        r.result_value = 32'(acc);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            ic_reg  = 5'd1;
            h_reg   = 6'd32;
            w_reg   = 6'd32;
            f_reg   = 5'd1;
            k_reg   = 3'd3;
            pad_reg = 2'd1;
            settle_sizes();
            conv_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IN_CHANNELS: ic_reg  = i_cfg_data[4:0];
                    REG_HEIGHT:      h_reg   = i_cfg_data[5:0];
                    REG_WIDTH:       w_reg   = i_cfg_data[5:0];
                    REG_FILTERS:     f_reg   = i_cfg_data[4:0];
                    REG_KERNEL_SIZE: k_reg   = i_cfg_data[2:0];
                    REG_PADDING:     pad_reg = i_cfg_data[1:0];
                    default: ;
                endcase
                settle_sizes();
            end
            if (i_result_valid && i_result_ready) begin
                if (conv_results_due.size() == 0) begin
                    $error("result with no compute outstanding: result_value %0d",
                           i_result_data.result_value);
                    mismatch_count++;
                end else begin
                    want = conv_results_due.pop_front();
                    if (i_result_data.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, i_result_data.result_value);
                        mismatch_count++;
                    end
                    if (i_result_data.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, i_result_data.saturated);
                        mismatch_count++;
                    end
                    if (i_result_data.bad_request !== want.bad_request) begin
                        $error("bad_request: expected %0b, got %0b",
                               want.bad_request, i_result_data.bad_request);
                        mismatch_count++;
                    end
                end
            end
            if (i_item_valid && i_item_ready) begin
                case (i_item_data.command)
                    CMD_LOAD_WEIGHT:
                        if (i_item_data.index < nf * nc * nk * nk && i_item_data.index < WGT_CELLS)
                            weight_mem[i_item_data.index] = i_item_data.value;
                    CMD_LOAD_PIXEL:
                        if (i_item_data.index < nc * nh * nw && i_item_data.index < PIX_CELLS)
                            pixel_mem[i_item_data.index] = i_item_data.value;
                    CMD_COMPUTE:
                        conv_results_due.push_back(conv_point(i_item_data));
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= conv_results_due.size();
    end

endmodule

// File: sim/conv2d_direct_engine_test.sv
`timescale 1ns / 1ps
// Top of the convolution engine testbench: clock, reset, config writes, item
// stimulus and result back-pressure, plus the final verdict.
// Depends on c2d_pkg, c2d_stream_if, conv2d_direct_engine and its checker.
module conv2d_direct_engine_test;
    import c2d_pkg::*;

    localparam int PIX_CELLS     = DEF_MAX_IN_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
    localparam int WGT_CELLS     = DEF_MAX_FILTERS * DEF_MAX_IN_CHANNELS
                                 * DEF_MAX_KERNEL * DEF_MAX_KERNEL;
    localparam int ITEM_W        = $bits(t_in_item);
    localparam int REG_SLOTS     = 1 << CFG_IDX_W;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_EVERY    = 500;
    localparam int LIMIT_NS      = 8_000_000;

    localparam logic [1:0]         CMD_NONE = 2'd3;
    localparam logic signed [15:0] VAL_MIN  = 16'sh8000;
    localparam logic signed [15:0] VAL_MAX  = 16'sh7FFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int tx_idle_pct = 21;
    int rx_idle_pct = 88;
    int chk_fails;
    int chk_pending;

    logic [CFG_DATA_W-1:0] reg_val [REG_SLOTS];
    int unsigned sz_c, sz_h, sz_w, sz_f, sz_k;

    c2d_stream_if #(.T(t_in_item))  item_ch ();
    c2d_stream_if #(.T(t_out_item)) result_ch ();

    conv2d_direct_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    conv2d_direct_engine_check conv_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_item_valid   (item_ch.valid),
        .i_item_ready   (item_ch.ready),
        .i_item_data    (item_ch.data),
        .i_result_valid (result_ch.valid),
        .i_result_ready (result_ch.ready),
        .i_result_data  (result_ch.data),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending)
    );

    initial forever #1 i_clk = ~i_clk;

    function automatic int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_item build_item(logic [1:0] cmd, logic [13:0] idx,
                                            logic signed [15:0] val, logic [3:0] of,
                                            logic [4:0] row, logic [4:0] col);
        t_in_item it;
        it.command    = cmd;
        it.index      = idx;
        it.value      = val;
        it.out_filter = of;
        it.out_row    = row;
        it.out_col    = col;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned roll;
        it   = ITEM_W'({$urandom(), $urandom()});
        roll = $urandom_range(99);
        if (roll < 45) begin
            it.command    = CMD_COMPUTE;
            it.out_filter = 4'($urandom_range(sz_f - 1));
            it.out_row    = 5'($urandom_range(sz_h - 1));
            it.out_col    = 5'($urandom_range(sz_w - 1));
        end else if (roll < 55) begin
            it.command = CMD_COMPUTE;
        end else if (roll < 75) begin
            it.command = CMD_LOAD_WEIGHT;
            it.index   = 14'($urandom_range(sz_f * sz_c * sz_k * sz_k - 1));
            it.value   = pick_value();
        end else if (roll < 92) begin
            it.command = CMD_LOAD_PIXEL;
            it.index   = 14'($urandom_range(sz_c * sz_h * sz_w - 1));
            it.value   = pick_value();
        end else if (roll < 96) begin
            it.command = $urandom_range(1) ? CMD_LOAD_WEIGHT : CMD_LOAD_PIXEL;
        end else begin
            it.command = CMD_NONE;
        end
        return it;
    endfunction

    task automatic offer(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    // drop valid, wait for every result, then let trailing loads finish
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [5:0] ic, h, w, f, k, pad);
        for (int r = 0; r < REG_SLOTS; r++) reg_val[r] = CFG_DATA_W'($urandom());
        reg_val[REG_IN_CHANNELS] = ic;
        reg_val[REG_HEIGHT]      = h;
        reg_val[REG_WIDTH]       = w;
        reg_val[REG_FILTERS]     = f;
        reg_val[REG_KERNEL_SIZE] = k;
        reg_val[REG_PADDING]     = pad;
        for (int r = 0; r < REG_SLOTS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(r);
            i_cfg_data <= reg_val[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sz_c = fit(reg_val[REG_IN_CHANNELS][4:0], 1, DEF_MAX_IN_CHANNELS);
        sz_h = fit(reg_val[REG_HEIGHT][5:0], 1, DEF_MAX_HEIGHT);
        sz_w = fit(reg_val[REG_WIDTH][5:0], 1, DEF_MAX_WIDTH);
        sz_f = fit(reg_val[REG_FILTERS][4:0], 1, DEF_MAX_FILTERS);
        sz_k = fit(reg_val[REG_KERNEL_SIZE][2:0], 1, DEF_MAX_KERNEL);
    endtask

    initial begin : result_side
        int hold_left;
        int taken;
        int next_hold;
        hold_left = 0;
        taken     = 0;
        next_hold = 120;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) taken++;
            if (hold_left > 0) begin
                hold_left--;
            end else if (taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += HOLD_EVERY;
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write every store entry once so no compute can read an unset cell
        configure(6'd16, 6'd32, 6'd32, 6'd16, 6'd5, 6'd1);
        for (int i = 0; i < PIX_CELLS; i++)
            offer(build_item(CMD_LOAD_PIXEL, 14'(i), pick_value(), 4'($urandom()),
                             5'($urandom()), 5'($urandom())));
        for (int i = 0; i < WGT_CELLS; i++)
            offer(build_item(CMD_LOAD_WEIGHT, 14'(i), pick_value(), 4'($urandom()),
                             5'($urandom()), 5'($urandom())));
        quiesce();

        // positive and negative clamp, ignored loads, bad coordinates
        configure(6'd3, 6'd1, 6'd1, 6'd1, 6'd1, 6'd0);
        for (int i = 0; i < 3; i++) offer(build_item(CMD_LOAD_PIXEL, 14'(i), VAL_MIN, 0, 0, 0));
        for (int i = 0; i < 3; i++) offer(build_item(CMD_LOAD_WEIGHT, 14'(i), VAL_MIN, 0, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++) offer(build_item(CMD_LOAD_WEIGHT, 14'(i), VAL_MAX, 0, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 0));
        offer(build_item(CMD_LOAD_PIXEL, 14'd3, VAL_MAX, 0, 0, 0));
        offer(build_item(CMD_LOAD_WEIGHT, '1, VAL_MAX, 0, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, '1, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, '1, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, '1));
        offer(build_item(CMD_NONE, '1, '1, '1, '1, '1));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 0));
        quiesce();

        // widest kernel and padding, corners and center
        configure(6'd1, 6'd5, 6'd5, 6'd2, 6'd5, 6'd2);
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 1, 4, 4));
        offer(build_item(CMD_COMPUTE, 0, 0, 1, 2, 2));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 4));
        quiesce();

        // register values outside their ranges
        configure(6'd0, 6'd0, 6'd63, 6'd31, 6'd7, 6'd3);
        offer(build_item(CMD_COMPUTE, 0, 0, 15, 0, 31));
        offer(build_item(CMD_COMPUTE, 0, 0, 0, 0, 0));
        offer(build_item(CMD_COMPUTE, 0, 0, 3, 1, 0));
        quiesce();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES / 3) begin
                tx_idle_pct = 88;
                rx_idle_pct = 21;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(9) < 7)
                configure(6'($urandom_range(4, 1)), 6'($urandom_range(8, 1)),
                          6'($urandom_range(8, 1)), 6'($urandom_range(4, 1)),
                          6'($urandom_range(3, 1)), 6'($urandom_range(2)));
            else
                configure(6'($urandom()), 6'($urandom()), 6'($urandom()),
                          6'($urandom()), 6'($urandom()), 6'($urandom()));
            repeat (PHASE_ITEMS) offer(random_item());
            quiesce();
        end

        if (chk_fails == 0 && chk_pending == 0) begin
            $display("[conv2d_direct_engine] OK");
        end else begin
            $display("[conv2d_direct_engine] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("[conv2d_direct_engine] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/c2d_pkg.sv
rtl/c2d_stream_if.sv
rtl/c2d_mac.sv
rtl/conv2d_direct_engine.sv
sim/conv2d_direct_engine_check.sv
sim/conv2d_direct_engine_test.sv
